// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Constants and types shared by the buddy page allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package bpa_pkg;
	localparam int PAGES     = 1024;
	localparam int PAGE_W    = 10;
	localparam int LINK_W    = 11;
	localparam int MAX_ORDER = 10;
	localparam int NORD      = 11;
	localparam int ORD_W     = 4;
	localparam int SC_W      = 16;
	localparam int FT_W      = 11;
	localparam int SZ_W      = 12;

	localparam logic [LINK_W-1:0] EMPTY = LINK_W'(PAGES);

	typedef enum logic [1:0] {
		REQ_ALLOC  = 2'd0,
		REQ_FREE   = 2'd1,
		REQ_RETAIN = 2'd2,
		REQ_QUERY  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISP,
		ST_A_POP,
		ST_A_SPLIT,
		ST_A_SC,
		ST_F_SH,
		ST_F_CHK,
		ST_F_RD,
		ST_R_SH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load_in;
		logic alloc_start;
		logic pop_head;
		logic split_step;
		logic rd_share_b;
		logic alloc_sc;
		logic rd_share_pg;
		logic free_share;
		logic free_begin;
		logic walk_rd;
		logic walk_adv;
		logic walk_unlink;
		logic push;
		logic share_done;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic ord_zero;
		logic ord_bad;
		logic free_bad;
		logic found;
		logic split_more;
		logic share_gt1;
		logic walk_end;
		logic walk_hit;
		logic merge_ok;
		logic clr_done;
		logic out_free;
	} status_t;
endpackage
`default_nettype wire

// File: hw/rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Request sequencer: steps the datapath through alloc, free and share requests.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  bpa_pkg::status_t  status,
	output bpa_pkg::cmd_t     cmd
);
	bpa_pkg::state_t state_q;
	bpa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bpa_pkg::ST_CLEAR: begin
				if (status.clr_done) state_d = bpa_pkg::ST_IDLE;
			end
			bpa_pkg::ST_IDLE: begin
				if (in_valid) state_d = bpa_pkg::ST_DISP;
			end
			bpa_pkg::ST_DISP: begin
				case (status.req)
					bpa_pkg::REQ_ALLOC: begin
						state_d = (status.ord_bad || !status.found) ?
							bpa_pkg::ST_DONE : bpa_pkg::ST_A_POP;
					end
					bpa_pkg::REQ_FREE: begin
						state_d = status.free_bad ? bpa_pkg::ST_DONE : bpa_pkg::ST_F_SH;
					end
					default: state_d = bpa_pkg::ST_R_SH;
				endcase
			end
			bpa_pkg::ST_A_POP:   state_d = bpa_pkg::ST_A_SPLIT;
			bpa_pkg::ST_A_SPLIT: begin
				if (!status.split_more) state_d = bpa_pkg::ST_A_SC;
			end
			bpa_pkg::ST_A_SC:    state_d = bpa_pkg::ST_DONE;
			bpa_pkg::ST_F_SH: begin
				state_d = (status.ord_zero && status.share_gt1) ?
					bpa_pkg::ST_DONE : bpa_pkg::ST_F_CHK;
			end
			bpa_pkg::ST_F_CHK: begin
				state_d = (!status.merge_ok || status.walk_end) ?
					bpa_pkg::ST_DONE : bpa_pkg::ST_F_RD;
			end
			bpa_pkg::ST_F_RD:    state_d = bpa_pkg::ST_F_CHK;
			bpa_pkg::ST_R_SH:    state_d = bpa_pkg::ST_DONE;
			bpa_pkg::ST_DONE: begin
				if (status.out_free) state_d = bpa_pkg::ST_IDLE;
			end
			default: state_d = bpa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			bpa_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			bpa_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			bpa_pkg::ST_DISP: begin
				case (status.req)
					bpa_pkg::REQ_ALLOC: cmd.alloc_start = !status.ord_bad && status.found;
					bpa_pkg::REQ_FREE:  cmd.rd_share_pg = !status.free_bad;
					default:            cmd.rd_share_pg = 1'b1;
				endcase
			end
			bpa_pkg::ST_A_POP: cmd.pop_head = 1'b1;
			bpa_pkg::ST_A_SPLIT: begin
				cmd.split_step = status.split_more;
				cmd.rd_share_b = !status.split_more;
			end
			bpa_pkg::ST_A_SC: cmd.alloc_sc = 1'b1;
			bpa_pkg::ST_F_SH: begin
				cmd.free_share = 1'b1;
				cmd.free_begin = !(status.ord_zero && status.share_gt1);
			end
			bpa_pkg::ST_F_CHK: begin
				cmd.push    = !status.merge_ok || status.walk_end;
				cmd.walk_rd = status.merge_ok && !status.walk_end;
			end
			bpa_pkg::ST_F_RD: begin
				cmd.walk_unlink = status.walk_hit;
				cmd.walk_adv    = !status.walk_hit;
			end
			bpa_pkg::ST_R_SH: cmd.share_done = 1'b1;
			bpa_pkg::ST_DONE: cmd.out_load = status.out_free;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// File: hw/rtl/bpa_dp.sv
// ----------------------------------------------------------------------------
// bpa_dp
// Allocator datapath: list heads, link and share memories, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module bpa_dp (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  [1:0]                       in_req,
	input  wire  [bpa_pkg::PAGE_W-1:0]       in_page,
	input  wire  [bpa_pkg::ORD_W-1:0]        in_order,
	input  bpa_pkg::cmd_t                    cmd,
	output bpa_pkg::status_t                 status,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic                             out_ok,
	output logic [bpa_pkg::PAGE_W-1:0]       out_block_page,
	output logic                             out_released,
	output logic [bpa_pkg::SC_W-1:0]         out_share_count,
	output logic [bpa_pkg::FT_W-1:0]         out_free_pages
);
	logic [bpa_pkg::LINK_W-1:0] head_q [bpa_pkg::NORD];
	logic [bpa_pkg::LINK_W-1:0] link_mem [bpa_pkg::PAGES];
	logic [bpa_pkg::SC_W-1:0]   share_mem [bpa_pkg::PAGES];

	bpa_pkg::req_t              req_q;
	logic [bpa_pkg::PAGE_W-1:0] pg_q, b_q, p_q, clr_q;
	logic [bpa_pkg::ORD_W-1:0]  ord_q, f_q, o_q;
	logic [bpa_pkg::LINK_W-1:0] cur_q, prev_q, steps_q, link_rd_q;
	logic [bpa_pkg::SC_W-1:0]   share_rd_q;
	logic [bpa_pkg::FT_W-1:0]   free_q;
	logic                       res_ok_q, res_rel_q;
	logic [bpa_pkg::PAGE_W-1:0] res_blk_q;
	logic [bpa_pkg::SC_W-1:0]   res_sc_q;
	logic                       m_valid_q, m_ok_q, m_rel_q;
	logic [bpa_pkg::PAGE_W-1:0] m_blk_q;
	logic [bpa_pkg::SC_W-1:0]   m_sc_q;
	logic [bpa_pkg::FT_W-1:0]   m_free_q;

	logic                       found;
	logic [bpa_pkg::ORD_W-1:0]  found_f, nf;
	logic [bpa_pkg::SZ_W-1:0]   sz, free_sum;
	logic [bpa_pkg::PAGE_W-1:0] split_addr, bud;
	logic [bpa_pkg::SC_W-1:0]   retain_val, dec_val;
	logic                       share_nz;

	logic                       link_we, link_re, sh_we, sh_re;
	logic [bpa_pkg::PAGE_W-1:0] link_wa, link_ra, sh_wa, sh_ra;
	logic [bpa_pkg::LINK_W-1:0] link_wd;
	logic [bpa_pkg::SC_W-1:0]   sh_wd;

	// Smallest non-empty order at or above the requested one.
	always_comb begin
		found   = 1'b0;
		found_f = '0;
		for (int i = 0; i < bpa_pkg::NORD; i++) begin
			if (!found && (bpa_pkg::ORD_W'(i) >= ord_q) && (head_q[i] < bpa_pkg::EMPTY)) begin
				found   = 1'b1;
				found_f = bpa_pkg::ORD_W'(i);
			end
		end
	end

	assign nf         = f_q - 1'b1;
	assign sz         = bpa_pkg::SZ_W'(1) << ord_q;
	assign free_sum   = {1'b0, free_q} + sz;
	assign split_addr = b_q + (bpa_pkg::PAGE_W'(1) << nf);
	assign bud        = p_q ^ (bpa_pkg::PAGE_W'(1) << o_q);
	assign share_nz   = share_rd_q != '0;
	assign dec_val    = share_rd_q - 1'b1;
	assign retain_val = (share_rd_q == '0) ? bpa_pkg::SC_W'(2) :
		((share_rd_q == '1) ? share_rd_q : share_rd_q + 1'b1);

	always_comb begin
		status.req        = req_q;
		status.ord_zero   = ord_q == '0;
		status.ord_bad    = ord_q > bpa_pkg::ORD_W'(bpa_pkg::MAX_ORDER);
		status.free_bad   = (ord_q > bpa_pkg::ORD_W'(bpa_pkg::MAX_ORDER)) ||
			(({2'b00, pg_q} + sz) > bpa_pkg::SZ_W'(bpa_pkg::PAGES)) ||
			((pg_q & bpa_pkg::PAGE_W'(sz - 1'b1)) != '0);
		status.found      = found;
		status.split_more = f_q > ord_q;
		status.share_gt1  = share_rd_q > bpa_pkg::SC_W'(1);
		status.walk_end   = (cur_q >= bpa_pkg::EMPTY) ||
			(steps_q == bpa_pkg::LINK_W'(bpa_pkg::PAGES));
		status.walk_hit   = cur_q == {1'b0, bud};
		status.merge_ok   = o_q < bpa_pkg::ORD_W'(bpa_pkg::MAX_ORDER);
		status.clr_done   = clr_q == bpa_pkg::PAGE_W'(bpa_pkg::PAGES - 1);
		status.out_free   = !m_valid_q || out_ready;
	end

	always_comb begin
		link_we = 1'b0;
		link_wa = p_q;
		link_wd = head_q[o_q];
		if (cmd.split_step) begin
			link_we = 1'b1;
			link_wa = split_addr;
			link_wd = head_q[nf];
		end else if (cmd.walk_unlink && (prev_q < bpa_pkg::EMPTY)) begin
			link_we = 1'b1;
			link_wa = prev_q[bpa_pkg::PAGE_W-1:0];
			link_wd = link_rd_q;
		end else if (cmd.push) begin
			link_we = 1'b1;
		end
		link_re = cmd.alloc_start || cmd.walk_rd;
		link_ra = cmd.alloc_start ? head_q[found_f][bpa_pkg::PAGE_W-1:0] :
			cur_q[bpa_pkg::PAGE_W-1:0];
	end

	always_comb begin
		sh_we = 1'b0;
		sh_wa = pg_q;
		sh_wd = retain_val;
		if (cmd.clr_step) begin
			sh_we = 1'b1;
			sh_wa = clr_q;
			sh_wd = '0;
		end else if (cmd.free_share && (ord_q == '0) && share_nz) begin
			sh_we = 1'b1;
			sh_wd = dec_val;
		end else if (cmd.share_done && (req_q == bpa_pkg::REQ_RETAIN)) begin
			sh_we = 1'b1;
		end
		sh_re = cmd.rd_share_b || cmd.rd_share_pg;
		sh_ra = cmd.rd_share_b ? b_q : pg_q;
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		if (link_re) link_rd_q <= link_mem[link_ra];
	end

	always_ff @(posedge clk) begin
		if (sh_we) share_mem[sh_wa] <= sh_wd;
		if (sh_re) share_rd_q <= share_mem[sh_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bpa_pkg::NORD; i++) head_q[i] <= bpa_pkg::EMPTY;
			free_q    <= '0;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.pop_head) head_q[f_q] <= link_rd_q;
			if (cmd.split_step) head_q[nf] <= {1'b0, split_addr};
			if (cmd.walk_unlink && (prev_q >= bpa_pkg::EMPTY)) head_q[o_q] <= link_rd_q;
			if (cmd.push) head_q[o_q] <= {1'b0, p_q};
			if (cmd.alloc_sc) begin
				free_q <= ({1'b0, free_q} >= sz) ? (free_q - sz[bpa_pkg::FT_W-1:0]) : '0;
			end
			if (cmd.free_begin) begin
				free_q <= (free_sum > bpa_pkg::SZ_W'(bpa_pkg::PAGES)) ?
					bpa_pkg::FT_W'(bpa_pkg::PAGES) : free_sum[bpa_pkg::FT_W-1:0];
			end
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q     <= bpa_pkg::req_t'(in_req);
			pg_q      <= in_page;
			ord_q     <= in_order;
			res_ok_q  <= 1'b0;
			res_rel_q <= 1'b0;
			res_blk_q <= '0;
			res_sc_q  <= '0;
		end
		if (cmd.alloc_start) begin
			f_q <= found_f;
			b_q <= head_q[found_f][bpa_pkg::PAGE_W-1:0];
		end
		if (cmd.split_step) f_q <= nf;
		if (cmd.alloc_sc) begin
			res_ok_q  <= 1'b1;
			res_blk_q <= b_q;
			res_sc_q  <= share_rd_q;
		end
		if (cmd.free_share) begin
			res_ok_q <= 1'b1;
			res_sc_q <= ((ord_q == '0) && share_nz) ? dec_val : share_rd_q;
		end
		if (cmd.free_begin) begin
			res_rel_q <= 1'b1;
			p_q       <= pg_q;
			o_q       <= ord_q;
			cur_q     <= head_q[ord_q];
			prev_q    <= bpa_pkg::EMPTY;
			steps_q   <= '0;
		end
		if (cmd.walk_adv) begin
			prev_q  <= cur_q;
			cur_q   <= link_rd_q;
			steps_q <= steps_q + 1'b1;
		end
		// The buddy is gone from its list; carry on one order up with the merged block.
		if (cmd.walk_unlink) begin
			p_q     <= (bud < p_q) ? bud : p_q;
			o_q     <= o_q + 1'b1;
			cur_q   <= head_q[o_q + 1'b1];
			prev_q  <= bpa_pkg::EMPTY;
			steps_q <= '0;
		end
		if (cmd.share_done) begin
			res_ok_q <= 1'b1;
			res_sc_q <= (req_q == bpa_pkg::REQ_RETAIN) ? retain_val : share_rd_q;
		end
		if (cmd.out_load) begin
			m_ok_q   <= res_ok_q;
			m_blk_q  <= res_blk_q;
			m_rel_q  <= res_rel_q;
			m_sc_q   <= res_sc_q;
			m_free_q <= free_q;
		end
	end

	assign out_valid       = m_valid_q;
	assign out_ok          = m_ok_q;
	assign out_block_page  = m_blk_q;
	assign out_released    = m_rel_q;
	assign out_share_count = m_sc_q;
	assign out_free_pages  = m_free_q;
endmodule
`default_nettype wire

// File: hw/rtl/buddy_page_allocator.sv
// From accept to result, alloc steps through dispatch, head pop, one split per order split
// and a share read; free through dispatch, share update and the buddy search (a check and a
// read per list node visited); retain and query through dispatch and a share step. A failed
// alloc or rejected free stops at dispatch, a share-only free after the update.
// One request is in flight at a time; walks through the link memory port set the rate, and
// a full output stalls it. A pass after reset clears the share counts before any request.
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator with per-order free lists and per-page share counts.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module buddy_page_allocator (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [15:0] s_axis_tdata,   // page[9:0], order[13:10], zero fill
	input  wire  [1:0]  s_axis_tuser,   // req_type[1:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,   // block_page[9:0], released[10],
	                                    // share_count[26:11], free_pages[37:27], zero fill
	output logic [0:0]  m_axis_tuser    // ok[0]
);
	bpa_pkg::cmd_t    cmd;
	bpa_pkg::status_t status;

	logic                         out_ok, out_released;
	logic [bpa_pkg::PAGE_W-1:0]   out_block_page;
	logic [bpa_pkg::SC_W-1:0]     out_share_count;
	logic [bpa_pkg::FT_W-1:0]     out_free_pages;

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bpa_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_req          (s_axis_tuser),
		.in_page         (s_axis_tdata[9:0]),
		.in_order        (s_axis_tdata[13:10]),
		.cmd             (cmd),
		.status          (status),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_ok          (out_ok),
		.out_block_page  (out_block_page),
		.out_released    (out_released),
		.out_share_count (out_share_count),
		.out_free_pages  (out_free_pages)
	);

	assign m_axis_tdata = {2'b00, out_free_pages, out_share_count, out_released, out_block_page};
	assign m_axis_tuser = out_ok;

	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`ASSERT_IMPLIES(a_free_bound, clk, arst_n, m_axis_tvalid, m_axis_tdata[37:27] <= 11'd1024)
	`ASSERT_IMPLIES(a_fail_clean, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[10:0] == 11'd0)
endmodule
`default_nettype wire

// File: tb/buddy_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_checker
// Watches both streams of the buddy page allocator, predicts each result from
// its own copy of the free lists and share counts, and compares field by field.
// ----------------------------------------------------------------------------
module buddy_checker
	import bpa_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	input  wire         s_axis_tready,
	input  wire  [15:0] s_axis_tdata,
	input  wire  [1:0]  s_axis_tuser,
	input  wire         m_axis_tvalid,
	input  wire         m_axis_tready,
	input  wire  [39:0] m_axis_tdata,
	input  wire  [0:0]  m_axis_tuser,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		logic              ok;
		logic [PAGE_W-1:0] block_page;
		logic              released;
		logic [SC_W-1:0]   share_count;
		logic [FT_W-1:0]   free_pages;
	} alloc_result_t;

	logic [LINK_W-1:0] heads [NORD];
	logic [LINK_W-1:0] links [PAGES];
	logic [SC_W-1:0]   shares [PAGES];
	int                free_tot;
	alloc_result_t     expected_results [$];

	assign pending = expected_results.size();

	function automatic void push_block(int pg, int ord);
		links[pg] = heads[ord];
		heads[ord] = LINK_W'(pg);
	endfunction

	// Walks are bounded, so a corrupted list with a cycle ends as a miss.
	function automatic bit unlink_buddy(int pg, int ord);
		int cur;
		int prev;
		int steps;
		cur = heads[ord];
		prev = PAGES;
		steps = 0;
		while (cur < PAGES && steps < PAGES) begin
			if (cur == pg) begin
				if (prev == PAGES)
					heads[ord] = links[cur];
				else
					links[prev] = links[cur];
				return 1'b1;
			end
			prev = cur;
			cur = links[cur];
			steps++;
		end
		return 1'b0;
	endfunction

	function automatic alloc_result_t allocator_step(req_t req, int pg, int ord);
		alloc_result_t r;
		int f;
		int b;
		int sz;
		int p;
		int o;
		int bud;
		bit go;
		r = '0;
		sz = 1 << ord;
		case (req)
			REQ_ALLOC: begin
				if (ord <= MAX_ORDER) begin
					f = ord;
					while (f <= MAX_ORDER && heads[f] >= PAGES)
						f++;
					if (f <= MAX_ORDER) begin
						b = heads[f];
						heads[f] = links[b];
						while (f > ord) begin
							f--;
							push_block(b + (1 << f), f);
						end
						free_tot = (free_tot >= sz) ? free_tot - sz : 0;
						r.ok = 1'b1;
						r.block_page = PAGE_W'(b);
						r.share_count = shares[b];
					end
				end
			end
			REQ_FREE: begin
				if (ord <= MAX_ORDER && pg + sz <= PAGES && (pg & (sz - 1)) == 0) begin
					r.ok = 1'b1;
					go = 1'b1;
					if (ord == 0 && shares[pg] != 0) begin
						shares[pg]--;
						if (shares[pg] != 0)
							go = 1'b0;
					end
					r.share_count = shares[pg];
					if (go) begin
						r.released = 1'b1;
						free_tot += sz;
						if (free_tot > PAGES)
							free_tot = PAGES;
						p = pg;
						o = ord;
						while (o < MAX_ORDER) begin
							bud = p ^ (1 << o);
							if (!unlink_buddy(bud, o))
								break;
							if (bud < p)
								p = bud;
							o++;
						end
						push_block(p, o);
					end
				end
			end
			default: begin
				r.ok = 1'b1;
				if (req == REQ_RETAIN) begin
					if (shares[pg] == 0)
						shares[pg] = 2;
					else if (shares[pg] != 16'hffff)
						shares[pg]++;
				end
				r.share_count = shares[pg];
			end
		endcase
		r.free_pages = FT_W'(free_tot);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t got;
		alloc_result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < NORD; i++)
				heads[i] = EMPTY;
			for (int i = 0; i < PAGES; i++) begin
				links[i] = '0;
				shares[i] = '0;
			end
			free_tot = 0;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.ok = m_axis_tuser[0];
				got.block_page = m_axis_tdata[9:0];
				got.released = m_axis_tdata[10];
				got.share_count = m_axis_tdata[26:11];
				got.free_pages = m_axis_tdata[37:27];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result ok=%0b page=%0d", $time, got.ok,
						got.block_page);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got != exp_r || m_axis_tdata[39:38] != 2'b00) begin
						$display("%0t: expected ok=%0b page=%0d rel=%0b sc=%0d free=%0d",
							$time, exp_r.ok, exp_r.block_page, exp_r.released,
							exp_r.share_count, exp_r.free_pages);
						$display("%0t:   actual ok=%0b page=%0d rel=%0b sc=%0d free=%0d",
							$time, got.ok, got.block_page, got.released,
							got.share_count, got.free_pages);
						fail_count++;
					end
				end
			end
			// The request comes after the result of this edge in program order,
			// which matches the block: one result per request, in order.
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(allocator_step(req_t'(s_axis_tuser),
					int'(s_axis_tdata[9:0]), int'(s_axis_tdata[13:10])));
		end
	end
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the buddy page allocator: directed corner requests, then random
// of all kinds, frees mostly of owned blocks, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import bpa_pkg::*;

	typedef struct {
		int pg;
		int ord;
	} owned_block_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	int          fail_count;
	int          pending;
	int          snd_idle;
	int          rcv_idle;
	logic        rcv_hold;

	owned_block_t owned [$];
	int           sent_req [$];
	int           sent_ord [$];

	buddy_page_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	buddy_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= !rcv_hold && ($urandom_range(99) >= rcv_idle);
	end

	// Learn which blocks were handed out, so later frees hit real allocations.
	always @(posedge clk) begin
		int rq;
		int ro;
		owned_block_t blk;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready && sent_req.size() != 0) begin
				rq = sent_req.pop_front();
				ro = sent_ord.pop_front();
				if (rq == REQ_ALLOC && m_axis_tuser[0]) begin
					blk.pg = m_axis_tdata[9:0];
					blk.ord = ro;
					owned.push_back(blk);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				sent_req.push_back(int'(s_axis_tuser));
				sent_ord.push_back(int'(s_axis_tdata[13:10]));
			end
		end
	end

	// Called at a rising edge; returns at the accept edge or after an idle gap.
	task automatic send_item(req_t req, int pg, int ord);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {2'b00, 4'(ord), 10'(pg)};
		do
			@(negedge clk);
		while (!s_axis_tready);
		@(posedge clk);
		if ($urandom_range(99) < snd_idle) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_random();
		int r;
		int idx;
		owned_block_t blk;
		r = $urandom_range(99);
		if (r < 40) begin
			send_item(REQ_ALLOC, $urandom_range(1023),
				($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(15));
		end else if (r < 72 && owned.size() != 0) begin
			idx = $urandom_range(owned.size() - 1);
			blk = owned[idx];
			owned.delete(idx);
			send_item(REQ_FREE, blk.pg, blk.ord);
		end else if (r < 82 && owned.size() != 0) begin
			idx = $urandom_range(owned.size() - 1);
			send_item(REQ_RETAIN, owned[idx].pg, $urandom_range(15));
		end else if (r < 90) begin
			send_item(REQ_QUERY, $urandom_range(1023), $urandom_range(15));
		end else begin
			send_item(req_t'($urandom_range(3)), $urandom_range(1023), $urandom_range(15));
		end
	endtask

	// The extra edge lets the checker count an item accepted at the calling edge.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_ALLOC;
		rcv_hold = 1'b0;
		snd_idle = 37;
		rcv_idle = 52;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: empty pool, rejected requests, sharing.
		send_item(REQ_ALLOC, 0, 0);
		send_item(REQ_FREE, 0, MAX_ORDER);
		send_item(REQ_ALLOC, 0, 11);
		send_item(REQ_ALLOC, 1023, 15);
		send_item(REQ_FREE, 0, 12);
		send_item(REQ_FREE, 3, 2);
		send_item(REQ_FREE, 1023, 1);
		send_item(REQ_QUERY, 1023, 0);
		send_item(REQ_ALLOC, 0, 0);
		send_item(REQ_ALLOC, 0, MAX_ORDER);
		send_item(REQ_RETAIN, 0, 0);
		send_item(REQ_RETAIN, 0, 0);
		send_item(REQ_FREE, 0, 0);
		send_item(REQ_FREE, 0, 0);
		send_item(REQ_QUERY, 0, 0);
		send_item(REQ_FREE, 0, 0);
		send_item(REQ_ALLOC, 0, 9);
		send_item(REQ_ALLOC, 0, 3);
		send_item(REQ_FREE, 512, 9);
		send_item(REQ_ALLOC, 0, 1);

		// Share one page a few times, then read its count back.
		drain();
		repeat (3) send_item(REQ_RETAIN, 700, 0);
		send_item(REQ_QUERY, 700, 0);

		for (int i = 0; i < 400; i++) begin
			if (i == 130) begin
				snd_idle = 52;
				rcv_idle = 37;
			end
			if (i == 200) begin
				drain();
				@(posedge clk);
			end
			if (i == 270) begin
				snd_idle = 0;
				rcv_idle = 0;
				fork
					begin
						rcv_hold = 1'b1;
						repeat (300) @(posedge clk);
						rcv_hold = 1'b0;
					end
				join_none
			end
			send_random();
		end

		// Double frees at the end: free count saturation and corrupt lists.
		send_item(REQ_FREE, 0, MAX_ORDER);
		send_item(REQ_FREE, 0, MAX_ORDER);
		send_item(REQ_ALLOC, 0, MAX_ORDER);
		send_item(REQ_ALLOC, 0, 0);
		send_item(REQ_ALLOC, 0, 2);
		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#500ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
